@@ src/hdd_pkg.sv @@
// Shared types, codes and reset constants for the harsh driving event detector.
package hdd_pkg;

  // Field widths of one GPS sample and of the register port
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned COURSE_W = 9;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned SPAN_W   = 8;
  localparam int unsigned GAP_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned EVENT_W  = 3;

  // Default depth of the sample window
  localparam int unsigned WINDOW_DEPTH_DEF = 6;

  // Register reset values
  localparam logic [SPEED_W-1:0]  MIN_SPEED_RST       = 16'd700;
  localparam logic [COURSE_W-1:0] TURN_ANGLE_LOW_RST  = 9'd70;
  localparam logic [COURSE_W-1:0] TURN_ANGLE_HIGH_RST = 9'd120;
  localparam logic [SPEED_W-1:0]  TURN_MEAN_SPEED_RST = 16'd2800;
  localparam logic [SPEED_W-1:0]  ACCEL_LIMIT_RST     = 16'd900;
  localparam logic [SPEED_W-1:0]  DECEL_LIMIT_RST     = 16'd2000;
  localparam logic [SPAN_W-1:0]   MAX_WINDOW_SPAN_RST = 8'd6;

  // Compass limits for turns across north
  localparam logic [COURSE_W-1:0] ANG_WEST = 9'd270;
  localparam logic [COURSE_W-1:0] ANG_FULL = 9'd360;
  localparam logic [COURSE_W-1:0] ANG_EAST = 9'd90;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SPEED       = 3'd0,
    CFG_TURN_ANGLE_LOW  = 3'd1,
    CFG_TURN_ANGLE_HIGH = 3'd2,
    CFG_TURN_MEAN_SPEED = 3'd3,
    CFG_ACCEL_LIMIT     = 3'd4,
    CFG_DECEL_LIMIT     = 3'd5,
    CFG_MAX_WINDOW_SPAN = 3'd6
  } cfg_idx_t;

  // Event codes
  typedef enum logic [EVENT_W-1:0] {
    EV_NONE  = 3'd0,
    EV_LEFT  = 3'd1,
    EV_RIGHT = 3'd2,
    EV_ACCEL = 3'd3,
    EV_BRAKE = 3'd4
  } event_t;

  // Register file contents
  typedef struct packed {
    logic [SPEED_W-1:0]  min_speed;
    logic [COURSE_W-1:0] turn_angle_low;
    logic [COURSE_W-1:0] turn_angle_high;
    logic [SPEED_W-1:0]  turn_mean_speed;
    logic [SPEED_W-1:0]  accel_limit;
    logic [SPEED_W-1:0]  decel_limit;
    logic [SPAN_W-1:0]   max_window_span;
  } cfg_t;

  // Decision for one sample
  typedef struct packed {
    event_t ev;
    logic   accepted;
    logic   turn;
  } verdict_t;

endpackage

@@ src/hdd_judge.sv @@
// Combinational decision for one sample against the current window taps.
module hdd_judge #(
  parameter int unsigned WINDOW_DEPTH = hdd_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned SUM_W        = hdd_pkg::SPEED_W + $clog2(WINDOW_DEPTH)
) (
  input  hdd_pkg::cfg_t                    cfg,
  input  logic [hdd_pkg::SPEED_W-1:0]      speed,
  input  logic [hdd_pkg::COURSE_W-1:0]     course,
  input  logic [hdd_pkg::TICK_W-1:0]       tick,
  input  logic [hdd_pkg::SPEED_W-1:0]      prv_speed,
  input  logic [hdd_pkg::TICK_W-1:0]       prv_tick,
  input  logic [hdd_pkg::COURSE_W-1:0]     old_course,
  input  logic [hdd_pkg::TICK_W-1:0]       old_tick,
  input  logic [hdd_pkg::SPEED_W-1:0]      drop_speed,
  input  logic [SUM_W-1:0]                 speed_sum,
  output logic [SUM_W-1:0]                 speed_sum_nxt,
  output hdd_pkg::verdict_t                verdict
);
  import hdd_pkg::*;

  logic [TICK_W-1:0]   span;
  logic                in_span;
  logic [COURSE_W-1:0] ang;
  logic [SUM_W-1:0]    mean_thr;
  logic                turn_hit;
  event_t              turn_dir;
  logic [GAP_W-1:0]    gap;
  logic [SPEED_W-1:0]  rise;
  logic [SPEED_W-1:0]  fall;
  logic [SPEED_W+GAP_W-1:0] accel_thr;
  logic [SPEED_W+GAP_W-1:0] decel_thr;
  logic                accepted;
  event_t              ev;

  // Accept only samples above the minimum speed
  assign accepted = speed > cfg.min_speed;

  // Running sum once the oldest entry falls out
  assign speed_sum_nxt = speed_sum - SUM_W'(drop_speed) + SUM_W'(speed);

  // Window span, modulo 2^32
  assign span    = tick - old_tick;
  assign in_span = span <= TICK_W'(cfg.max_window_span);

  // Course change and mean speed test (sum against limit times depth)
  assign ang      = (course >= old_course) ? course - old_course : old_course - course;
  assign mean_thr = SUM_W'(cfg.turn_mean_speed) * SUM_W'(WINDOW_DEPTH);
  assign turn_hit = (ang >= cfg.turn_angle_low) && (ang <= cfg.turn_angle_high) &&
                    (speed_sum_nxt >= mean_thr);

  // Turn direction: wrap across north first, then signed difference
  always_comb begin
    priority if (course >= ANG_WEST && course < ANG_FULL && old_course <= ANG_EAST) begin
      turn_dir = EV_LEFT;
    end else if (old_course >= ANG_WEST && old_course < ANG_FULL && course <= ANG_EAST) begin
      turn_dir = EV_RIGHT;
    end else if (course > old_course) begin
      turn_dir = EV_RIGHT;
    end else begin
      turn_dir = EV_LEFT;
    end
  end

  // Speed change against limit times the 8-bit tick gap
  assign gap       = GAP_W'(tick - prv_tick);
  assign rise      = speed - prv_speed;
  assign fall      = prv_speed - speed;
  assign accel_thr = (SPEED_W+GAP_W)'(cfg.accel_limit) * (SPEED_W+GAP_W)'(gap);
  assign decel_thr = (SPEED_W+GAP_W)'(cfg.decel_limit) * (SPEED_W+GAP_W)'(gap);

  // Pick the event
  always_comb begin
    priority if (!accepted || !in_span) begin
      ev = EV_NONE;
    end else if (turn_hit) begin
      ev = turn_dir;
    end else if (speed > prv_speed &&
                 (SPEED_W+GAP_W)'(rise) >= accel_thr) begin
      ev = EV_ACCEL;
    end else if (speed < prv_speed &&
                 (SPEED_W+GAP_W)'(fall) >= decel_thr) begin
      ev = EV_BRAKE;
    end else begin
      ev = EV_NONE;
    end
  end

  assign verdict.ev       = ev;
  assign verdict.accepted = accepted;
  assign verdict.turn     = accepted && in_span && turn_hit;

endmodule

@@ src/harsh_driving_event_detector.sv @@
// Top level of the harsh driving event detector: registers, sample window and pipeline.
// One GPS sample enters per clock when the output is not stalled and passes the input
// and result registers; the window of the last WINDOW_DEPTH accepted samples sits in
// shift registers with a running speed sum, so every decision is a single pass through
// the judge logic between the input register and the result register. Each sample
// gives exactly one result: the event code and whether the sample entered the window.
// Register writes are taken in any cycle (cfg_ready is always high) and must only be
// made while no sample is in flight.
module harsh_driving_event_detector #(
  parameter int unsigned WINDOW_DEPTH = hdd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hdd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hdd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hdd_pkg::SPEED_W-1:0]       in_speed,
  input  logic [hdd_pkg::COURSE_W-1:0]      in_course,
  input  logic [hdd_pkg::TICK_W-1:0]        in_tick,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hdd_pkg::EVENT_W-1:0]       out_event_res,
  output logic                              out_accepted
);
  import hdd_pkg::*;

  localparam int unsigned SUM_W = SPEED_W + $clog2(WINDOW_DEPTH);

  cfg_t                cfg_r;

  logic                s1_valid_r;
  logic [SPEED_W-1:0]  s1_speed_r;
  logic [COURSE_W-1:0] s1_course_r;
  logic [TICK_W-1:0]   s1_tick_r;

  logic [SPEED_W-1:0]  win_speed_r  [WINDOW_DEPTH];
  logic [COURSE_W-1:0] win_course_r [WINDOW_DEPTH];
  logic [TICK_W-1:0]   win_tick_r   [WINDOW_DEPTH];
  logic [SUM_W-1:0]    speed_sum_r;
  logic [SUM_W-1:0]    speed_sum_nxt;

  logic                out_valid_r;
  logic [EVENT_W-1:0]  out_event_r;
  logic                out_accepted_r;

  verdict_t            verdict;
  logic                out_load;
  logic                s1_adv;
  logic                in_take;
  logic                win_upd;

  // Handshake control
  assign cfg_ready = 1'b1;
  assign out_load  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_load;
  assign in_stall  = s1_valid_r && !out_load;
  assign in_take   = in_valid && !in_stall;
  assign win_upd   = s1_adv && verdict.accepted;

  // Register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_speed       <= MIN_SPEED_RST;
      cfg_r.turn_angle_low  <= TURN_ANGLE_LOW_RST;
      cfg_r.turn_angle_high <= TURN_ANGLE_HIGH_RST;
      cfg_r.turn_mean_speed <= TURN_MEAN_SPEED_RST;
      cfg_r.accel_limit     <= ACCEL_LIMIT_RST;
      cfg_r.decel_limit     <= DECEL_LIMIT_RST;
      cfg_r.max_window_span <= MAX_WINDOW_SPAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_SPEED:       cfg_r.min_speed       <= cfg_data;
        CFG_TURN_ANGLE_LOW:  cfg_r.turn_angle_low  <= cfg_data[COURSE_W-1:0];
        CFG_TURN_ANGLE_HIGH: cfg_r.turn_angle_high <= cfg_data[COURSE_W-1:0];
        CFG_TURN_MEAN_SPEED: cfg_r.turn_mean_speed <= cfg_data;
        CFG_ACCEL_LIMIT:     cfg_r.accel_limit     <= cfg_data;
        CFG_DECEL_LIMIT:     cfg_r.decel_limit     <= cfg_data;
        CFG_MAX_WINDOW_SPAN: cfg_r.max_window_span <= cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: hold while the result side is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_speed_r  <= in_speed;
      s1_course_r <= in_course;
      s1_tick_r   <= in_tick;
    end
  end

  // Decision logic; newest at tap 0, oldest after the shift comes from the tap before last
  hdd_judge #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_W        (SUM_W)
  ) u_judge (
    .cfg           (cfg_r),
    .speed         (s1_speed_r),
    .course        (s1_course_r),
    .tick          (s1_tick_r),
    .prv_speed     (win_speed_r[0]),
    .prv_tick      (win_tick_r[0]),
    .old_course    (win_course_r[WINDOW_DEPTH-2]),
    .old_tick      (win_tick_r[WINDOW_DEPTH-2]),
    .drop_speed    (win_speed_r[WINDOW_DEPTH-1]),
    .speed_sum     (speed_sum_r),
    .speed_sum_nxt (speed_sum_nxt),
    .verdict       (verdict)
  );

  // Window: shift in accepted samples, clear all ticks on a turn
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_sum_r <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_speed_r[i]  <= '0;
        win_course_r[i] <= '0;
        win_tick_r[i]   <= '0;
      end
    end else if (win_upd) begin
      speed_sum_r     <= speed_sum_nxt;
      win_speed_r[0]  <= s1_speed_r;
      win_course_r[0] <= s1_course_r;
      win_tick_r[0]   <= verdict.turn ? '0 : s1_tick_r;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        win_speed_r[i]  <= win_speed_r[i-1];
        win_course_r[i] <= win_course_r[i-1];
        win_tick_r[i]   <= verdict.turn ? '0 : win_tick_r[i-1];
      end
    end
  end

  // Result register: advance when empty or taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_event_r    <= verdict.ev;
      out_accepted_r <= verdict.accepted;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;
  assign out_accepted  = out_accepted_r;

endmodule
